### src/srpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpi_pkg
// Shared widths, codes and payload types of the sphere ring pixel indexer.
// ----------------------------------------------------------------------------
package srpi_pkg;

   // Table depth default (rings); table holds one more entry for the total
   localparam int MAX_RINGS_DEFAULT = 1024;

   // Angle format: unsigned fixed point, one integer bit
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int ANGLE_W         = ANGLE_FRAC_BITS + 1;
   localparam logic [ANGLE_W-1:0] ANGLE_ONE = ANGLE_W'(1) << ANGLE_FRAC_BITS;

   // Field widths
   localparam int OP_W       = 2;
   localparam int RING_W     = 11;
   localparam int COL_W      = 12;
   localparam int PIX_W      = 21;
   localparam int RING_NUM_W = 10;
   localparam int POS_W      = 12;
   localparam int NPIX_W     = 12;
   localparam int STATUS_W   = 2;
   localparam int CSR_W      = 11;

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ANGLE  = 2'd1;
   localparam logic [OP_W-1:0] OP_DECODE = 2'd2;
   localparam logic [OP_W-1:0] OP_ENCODE = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RING   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_COLUMN = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_PIXEL  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [RING_W-1:0]  ring;
      logic [COL_W-1:0]   column;
      logic [PIX_W-1:0]   pixel;
      logic [PIX_W-1:0]   cumulative_count;
      logic [ANGLE_W-1:0] theta;
      logic [ANGLE_W-1:0] phi;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0]      pixel_index;
      logic [RING_NUM_W-1:0] ring_number;
      logic [POS_W-1:0]      ring_position;
      logic [NPIX_W-1:0]     ring_pixels;
      logic [STATUS_W-1:0]   status;
   } rsp_payload_type;

   // Finished result offered by the sequencer to the output register
   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } result_type;

endpackage

### src/sphere_ring_pixel_indexer.sv
`timescale 1ns / 1ps
// Steps per request; the next request is taken once the result leaves.
//   load, bad angle or bad encode ring: no table read; decode past the end:
//   total read; encode: ring start/end reads; angle: theta multiply, ring
//   reads, phi multiply; decode: total, a read per search step, ring reads.
// Reset clears the sequencer and output register and sets ring_count to 2;
// the cumulative table is undefined until software loads it.
// ----------------------------------------------------------------------------
// sphere_ring_pixel_indexer
// Ring/column/pixel index conversion over a software-loaded table of
// cumulative pixel counts per iso-latitude ring.
// ----------------------------------------------------------------------------
module sphere_ring_pixel_indexer #(
   parameter int MAX_RINGS = srpi_pkg::MAX_RINGS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  srpi_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output srpi_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_write,
   input  logic [srpi_pkg::CSR_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_RINGS + 1);
   localparam int CW = (AW > srpi_pkg::CSR_W) ? AW : srpi_pkg::CSR_W;

   logic [AW-1:0]              ring_total_ff, ring_total_in;
   logic [CW-1:0]              csr_wide;
   logic                       rsp_valid_ff, rsp_valid_in;
   srpi_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   srpi_pkg::result_type       result;
   logic                       result_ready;
   logic                       mem_wr_en;
   logic [AW-1:0]              mem_wr_addr;
   logic [srpi_pkg::PIX_W-1:0] mem_wr_data;
   logic                       mem_rd_en;
   logic [AW-1:0]              mem_rd_addr;
   logic [srpi_pkg::PIX_W-1:0] mem_rd_data;

   // Saturate ring_count into the usable range on write
   assign csr_wide = CW'(csr_wdata);
   always_comb begin
      ring_total_in = ring_total_ff;
      if (csr_write) begin
         if (csr_wide < CW'(2)) begin
            ring_total_in = AW'(2);
         end else if (csr_wide > CW'(MAX_RINGS)) begin
            ring_total_in = AW'(MAX_RINGS);
         end else begin
            ring_total_in = AW'(csr_wide);
         end
      end
   end

   // Load the output register when it is empty or being drained
   assign result_ready = !rsp_valid_ff || !rsp_stall;
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (result.valid && result_ready) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result.payload;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_total_ff <= AW'(2);
         rsp_valid_ff  <= 1'b0;
      end else begin
         ring_total_ff <= ring_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   srpi_ctrl #(
      .MAX_RINGS (MAX_RINGS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .ring_total   (ring_total_ff),
      .result       (result),
      .result_ready (result_ready),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   srpi_ram #(
      .WIDTH (srpi_pkg::PIX_W),
      .DEPTH (MAX_RINGS + 1)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

### src/srpi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpi_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module srpi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/srpi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpi_ctrl
// Request sequencer: table loads, ring lookup, binary search over the
// cumulative table and the shared angle multiplier.
// ----------------------------------------------------------------------------
module srpi_ctrl #(
   parameter int MAX_RINGS = srpi_pkg::MAX_RINGS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  srpi_pkg::req_payload_type           req_payload,
   input  logic [$clog2(MAX_RINGS + 1)-1:0]    ring_total,
   output srpi_pkg::result_type                result,
   input  logic                                result_ready,
   output logic                                mem_wr_en,
   output logic [$clog2(MAX_RINGS + 1)-1:0]    mem_wr_addr,
   output logic [srpi_pkg::PIX_W-1:0]          mem_wr_data,
   output logic                                mem_rd_en,
   output logic [$clog2(MAX_RINGS + 1)-1:0]    mem_rd_addr,
   input  logic [srpi_pkg::PIX_W-1:0]          mem_rd_data
);

   localparam int AW  = $clog2(MAX_RINGS + 1);
   localparam int CW  = (AW > srpi_pkg::RING_W) ? AW : srpi_pkg::RING_W;
   localparam int MBW = (AW > srpi_pkg::PIX_W) ? AW : srpi_pkg::PIX_W;
   localparam int PW  = srpi_pkg::ANGLE_W + MBW;
   localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (srpi_pkg::ANGLE_FRAC_BITS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANG_MUL,
      ST_ANG_RING,
      ST_DEC_TOP,
      ST_DEC_SRCH,
      ST_RD_NEXT,
      ST_GOT,
      ST_COL_MUL,
      ST_COL_FIN,
      ST_DONE
   } state_type;

   state_type                              state_ff, state_in;
   logic [srpi_pkg::OP_W-1:0]              op_ff, op_in;
   logic [srpi_pkg::COL_W-1:0]             col_ff, col_in;
   logic [srpi_pkg::PIX_W-1:0]             pix_ff, pix_in;
   logic [srpi_pkg::ANGLE_W-1:0]           theta_ff, theta_in;
   logic [srpi_pkg::ANGLE_W-1:0]           phi_ff, phi_in;
   logic [AW-1:0]                          lo_ff, lo_in;
   logic [AW-1:0]                          hi_ff, hi_in;
   logic [AW-1:0]                          mid_ff, mid_in;
   logic [AW-1:0]                          k_ff, k_in;
   logic [srpi_pkg::PIX_W-1:0]             base_ff, base_in;
   logic [srpi_pkg::PIX_W-1:0]             np_ff, np_in;
   logic [PW-1:0]                          prod_ff, prod_in;
   srpi_pkg::rsp_payload_type              res_ff, res_in;

   logic                                   accept;
   logic [CW-1:0]                          ring_wide;
   logic [CW-1:0]                          total_wide;
   logic                                   load_ok;
   logic [srpi_pkg::ANGLE_W-1:0]           mul_a;
   logic [MBW-1:0]                         mul_b;
   logic [PW-1:0]                          mul_prod;
   logic [AW-1:0]                          last_ring;
   logic [PW-1:0]                          ring_sum;
   logic [PW-1:0]                          ring_raw;
   logic [AW-1:0]                          ring_sat;
   logic [srpi_pkg::PIX_W-1:0]             size;
   logic                                   below;
   logic [AW-1:0]                          lo_nx;
   logic [AW-1:0]                          hi_nx;
   logic [AW:0]                            mid_sum;
   logic [AW-1:0]                          mid_nx;
   logic [PW-1:0]                          col_raw;
   logic [srpi_pkg::PIX_W-1:0]             np_m1;
   logic [srpi_pkg::PIX_W-1:0]             col_sat;

   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign ring_wide  = CW'(req_payload.ring);
   assign total_wide = CW'(ring_total);
   assign load_ok    = (ring_wide <= CW'(MAX_RINGS));

   // Table load goes straight to the write port
   assign mem_wr_en   = accept && (req_payload.op == srpi_pkg::OP_LOAD) && load_ok;
   assign mem_wr_addr = AW'(req_payload.ring);
   assign mem_wr_data = req_payload.cumulative_count;

   // Shared multiplier: theta * (rings - 1), then phi * ring size
   assign last_ring = ring_total - AW'(1);
   assign mul_a     = (state_ff == ST_ANG_MUL) ? theta_ff : phi_ff;
   assign mul_b     = (state_ff == ST_ANG_MUL) ? MBW'(last_ring) : MBW'(np_ff);
   assign mul_prod  = mul_a * mul_b;

   // Round theta product to a ring and clamp to the last ring
   assign ring_sum = prod_ff + ROUND_HALF;
   assign ring_raw = ring_sum >> srpi_pkg::ANGLE_FRAC_BITS;
   assign ring_sat = (ring_raw > PW'(last_ring)) ? last_ring : AW'(ring_raw);

   // Ring size from two neighboring table entries
   assign size = mem_rd_data - base_ff;

   // One binary-search step per table read
   assign below   = (pix_ff < mem_rd_data);
   assign lo_nx   = below ? lo_ff : mid_ff;
   assign hi_nx   = below ? mid_ff : hi_ff;
   assign mid_sum = {1'b0, lo_nx} + {1'b0, hi_nx};
   assign mid_nx  = AW'(mid_sum >> 1);

   // Scale phi into a column and clamp to the last column
   assign col_raw = prod_ff >> srpi_pkg::ANGLE_FRAC_BITS;
   assign np_m1   = np_ff - srpi_pkg::PIX_W'(1);
   always_comb begin
      if (np_ff == '0) begin
         col_sat = '0;
      end else if (col_raw > PW'(np_m1)) begin
         col_sat = np_m1;
      end else begin
         col_sat = srpi_pkg::PIX_W'(col_raw);
      end
   end

   // Next-state and datapath logic
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      col_in      = col_ff;
      pix_in      = pix_ff;
      theta_in    = theta_ff;
      phi_in      = phi_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      k_in        = k_ff;
      base_in     = base_ff;
      np_in       = np_ff;
      prod_in     = prod_ff;
      res_in      = res_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_payload.op;
               col_in   = req_payload.column;
               pix_in   = req_payload.pixel;
               theta_in = req_payload.theta;
               phi_in   = req_payload.phi;
               res_in   = '0;
               case (req_payload.op)
                  srpi_pkg::OP_LOAD: begin
                     res_in.status = load_ok ? srpi_pkg::STATUS_OK : srpi_pkg::STATUS_RING;
                     state_in      = ST_DONE;
                  end
                  srpi_pkg::OP_ANGLE: begin
                     if (req_payload.theta > srpi_pkg::ANGLE_ONE) begin
                        res_in.status = srpi_pkg::STATUS_RING;
                        state_in      = ST_DONE;
                     end else if (req_payload.phi > srpi_pkg::ANGLE_ONE) begin
                        res_in.status = srpi_pkg::STATUS_COLUMN;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_ANG_MUL;
                     end
                  end
                  srpi_pkg::OP_DECODE: begin
                     // Fetch the grand total first
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = ring_total;
                     state_in    = ST_DEC_TOP;
                  end
                  default: begin
                     if (ring_wide >= total_wide) begin
                        res_in.status = srpi_pkg::STATUS_RING;
                        state_in      = ST_DONE;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(req_payload.ring);
                        k_in        = AW'(req_payload.ring);
                        state_in    = ST_RD_NEXT;
                     end
                  end
               endcase
            end
         end

         ST_ANG_MUL: begin
            prod_in  = mul_prod;
            state_in = ST_ANG_RING;
         end

         ST_ANG_RING: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ring_sat;
            k_in        = ring_sat;
            state_in    = ST_RD_NEXT;
         end

         ST_DEC_TOP: begin
            if (pix_ff >= mem_rd_data) begin
               res_in.status = srpi_pkg::STATUS_PIXEL;
               state_in      = ST_DONE;
            end else begin
               lo_in       = '0;
               hi_in       = ring_total;
               mid_in      = ring_total >> 1;
               mem_rd_en   = 1'b1;
               mem_rd_addr = ring_total >> 1;
               state_in    = ST_DEC_SRCH;
            end
         end

         ST_DEC_SRCH: begin
            lo_in = lo_nx;
            hi_in = hi_nx;
            if ((hi_nx - lo_nx) > AW'(1)) begin
               mid_in      = mid_nx;
               mem_rd_en   = 1'b1;
               mem_rd_addr = mid_nx;
            end else begin
               // Search closed: fetch the ring start
               k_in        = lo_nx;
               mem_rd_en   = 1'b1;
               mem_rd_addr = lo_nx;
               state_in    = ST_RD_NEXT;
            end
         end

         ST_RD_NEXT: begin
            base_in     = mem_rd_data;
            mem_rd_en   = 1'b1;
            mem_rd_addr = k_ff + AW'(1);
            state_in    = ST_GOT;
         end

         ST_GOT: begin
            np_in = size;
            case (op_ff)
               srpi_pkg::OP_ANGLE: begin
                  state_in = ST_COL_MUL;
               end
               srpi_pkg::OP_DECODE: begin
                  res_in.pixel_index   = pix_ff;
                  res_in.ring_number   = srpi_pkg::RING_NUM_W'(k_ff);
                  res_in.ring_position = srpi_pkg::POS_W'(pix_ff - base_ff);
                  res_in.ring_pixels   = srpi_pkg::NPIX_W'(size);
                  res_in.status        = srpi_pkg::STATUS_OK;
                  state_in             = ST_DONE;
               end
               default: begin
                  if (srpi_pkg::PIX_W'(col_ff) >= size) begin
                     res_in.status = srpi_pkg::STATUS_COLUMN;
                  end else begin
                     res_in.pixel_index   = base_ff + srpi_pkg::PIX_W'(col_ff);
                     res_in.ring_number   = srpi_pkg::RING_NUM_W'(k_ff);
                     res_in.ring_position = col_ff;
                     res_in.ring_pixels   = srpi_pkg::NPIX_W'(size);
                     res_in.status        = srpi_pkg::STATUS_OK;
                  end
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_COL_MUL: begin
            prod_in  = mul_prod;
            state_in = ST_COL_FIN;
         end

         ST_COL_FIN: begin
            res_in.pixel_index   = base_ff + col_sat;
            res_in.ring_number   = srpi_pkg::RING_NUM_W'(k_ff);
            res_in.ring_position = srpi_pkg::POS_W'(col_sat);
            res_in.ring_pixels   = srpi_pkg::NPIX_W'(np_ff);
            res_in.status        = srpi_pkg::STATUS_OK;
            state_in             = ST_DONE;
         end

         ST_DONE: begin
            if (result_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff    <= op_in;
      col_ff   <= col_in;
      pix_ff   <= pix_in;
      theta_ff <= theta_in;
      phi_ff   <= phi_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      k_ff     <= k_in;
      base_ff  <= base_in;
      np_ff    <= np_in;
      prod_ff  <= prod_in;
      res_ff   <= res_in;
   end

   assign result.valid   = (state_ff == ST_DONE);
   assign result.payload = res_ff;

endmodule

### dv/srpi_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpi_result_checker
// Watches the request, result and register ports of the sphere ring pixel
// indexer, predicts each result from its own copy of the cumulative table and
// ring count, and compares every accepted result field by field in order.
// ----------------------------------------------------------------------------
module srpi_result_checker #(
   parameter int MAX_RINGS = srpi_pkg::MAX_RINGS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  srpi_pkg::req_payload_type  req_payload,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  srpi_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_write,
   input  logic [srpi_pkg::CSR_W-1:0] csr_wdata,
   output int                         error_count,
   output int                         checked_count,
   output int                         pending_count
);

   localparam longint unsigned ANGLE_HALF = 64'd1 << (srpi_pkg::ANGLE_FRAC_BITS - 1);

   // Shadow of the cumulative table and the ring count register
   logic [srpi_pkg::PIX_W-1:0] ring_start [0:MAX_RINGS];
   logic [srpi_pkg::CSR_W-1:0] ring_count;

   srpi_pkg::rsp_payload_type results_due [$];
   srpi_pkg::rsp_payload_type want;

   // Pixels in ring k, with 21-bit wrap
   function automatic logic [srpi_pkg::PIX_W-1:0] ring_width(input int unsigned k);
      return ring_start[k + 1] - ring_start[k];
   endfunction

   // Work out the result of one request against the current table
   function automatic srpi_pkg::rsp_payload_type predict_indexer_result(
         input srpi_pkg::req_payload_type item);
      srpi_pkg::rsp_payload_type  res;
      int unsigned                rings;
      int unsigned                lo;
      int unsigned                hi;
      int unsigned                mid;
      longint unsigned            ring_sel;
      longint unsigned            col_sel;
      longint unsigned            theta_wide;
      longint unsigned            phi_wide;
      logic [srpi_pkg::PIX_W-1:0] size;
      logic [srpi_pkg::PIX_W-1:0] offset;
      res = '0;
      // saturate the ring count to the legal range
      rings = ring_count;
      if (rings < 2) rings = 2;
      if (rings > MAX_RINGS) rings = MAX_RINGS;
      case (item.op)
         srpi_pkg::OP_LOAD: begin
            if (item.ring > MAX_RINGS) res.status = srpi_pkg::STATUS_RING;
         end
         srpi_pkg::OP_ANGLE: begin
            if (item.theta > srpi_pkg::ANGLE_ONE) begin
               res.status = srpi_pkg::STATUS_RING;
            end else if (item.phi > srpi_pkg::ANGLE_ONE) begin
               res.status = srpi_pkg::STATUS_COLUMN;
            end else begin
               // round theta onto a ring, then scale phi over that ring
               theta_wide = item.theta;
               phi_wide   = item.phi;
               ring_sel   = (theta_wide * (rings - 1) + ANGLE_HALF)
                            >> srpi_pkg::ANGLE_FRAC_BITS;
               if (ring_sel > rings - 1) ring_sel = rings - 1;
               size    = ring_width(int'(ring_sel));
               col_sel = 0;
               if (size != 0) begin
                  col_sel = (phi_wide * size) >> srpi_pkg::ANGLE_FRAC_BITS;
                  if (col_sel > size - 1) col_sel = size - 1;
               end
               res.pixel_index   = ring_start[int'(ring_sel)] + srpi_pkg::PIX_W'(col_sel);
               res.ring_number   = srpi_pkg::RING_NUM_W'(ring_sel);
               res.ring_position = srpi_pkg::POS_W'(col_sel);
               res.ring_pixels   = size[srpi_pkg::NPIX_W-1:0];
            end
         end
         srpi_pkg::OP_DECODE: begin
            if (item.pixel >= ring_start[rings]) begin
               res.status = srpi_pkg::STATUS_PIXEL;
            end else begin
               // binary search for the last ring starting at or below pixel
               lo = 0;
               hi = rings;
               while (hi - lo > 1) begin
                  mid = (lo + hi) >> 1;
                  if (item.pixel < ring_start[mid]) hi = mid;
                  else lo = mid;
               end
               offset            = item.pixel - ring_start[lo];
               size              = ring_width(lo);
               res.pixel_index   = item.pixel;
               res.ring_number   = srpi_pkg::RING_NUM_W'(lo);
               res.ring_position = offset[srpi_pkg::POS_W-1:0];
               res.ring_pixels   = size[srpi_pkg::NPIX_W-1:0];
            end
         end
         default: begin
            if (item.ring >= rings) begin
               res.status = srpi_pkg::STATUS_RING;
            end else begin
               size = ring_width(item.ring);
               if (item.column >= size) begin
                  res.status = srpi_pkg::STATUS_COLUMN;
               end else begin
                  res.pixel_index   = ring_start[item.ring] + item.column;
                  res.ring_number   = item.ring[srpi_pkg::RING_NUM_W-1:0];
                  res.ring_position = item.column;
                  res.ring_pixels   = size[srpi_pkg::NPIX_W-1:0];
               end
            end
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         results_due.delete();
         ring_count = srpi_pkg::CSR_W'(2);
      end else begin
         if (csr_write) ring_count = csr_wdata;
         // compare an accepted result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $error("result 0x%h arrived with no request outstanding", rsp_payload);
               error_count++;
            end else begin
               want = results_due.pop_front();
               checked_count++;
               if (rsp_payload.pixel_index !== want.pixel_index) begin
                  $error("pixel_index: expected %0d, actual %0d",
                         want.pixel_index, rsp_payload.pixel_index);
                  error_count++;
               end
               if (rsp_payload.ring_number !== want.ring_number) begin
                  $error("ring_number: expected %0d, actual %0d",
                         want.ring_number, rsp_payload.ring_number);
                  error_count++;
               end
               if (rsp_payload.ring_position !== want.ring_position) begin
                  $error("ring_position: expected %0d, actual %0d",
                         want.ring_position, rsp_payload.ring_position);
                  error_count++;
               end
               if (rsp_payload.ring_pixels !== want.ring_pixels) begin
                  $error("ring_pixels: expected %0d, actual %0d",
                         want.ring_pixels, rsp_payload.ring_pixels);
                  error_count++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, actual %0d",
                         want.status, rsp_payload.status);
                  error_count++;
               end
            end
         end
         // predict an accepted request, then apply a table load
         if (req_valid && !req_stall) begin
            results_due.push_back(predict_indexer_result(req_payload));
            if (req_payload.op == srpi_pkg::OP_LOAD && req_payload.ring <= MAX_RINGS)
               ring_start[req_payload.ring] = req_payload.cumulative_count;
         end
      end
      pending_count <= results_due.size();
   end

endmodule

### dv/sphere_ring_pixel_indexer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_ring_pixel_indexer_tb
// Loads cumulative ring tables, then drives directed and random table loads,
// angle conversions, pixel decodes and ring/column encodes over several ring
// counts, with random idling on both channels and a long result hold-off.
// ----------------------------------------------------------------------------
module sphere_ring_pixel_indexer_tb;

   localparam int          MAX_RINGS       = srpi_pkg::MAX_RINGS_DEFAULT;
   localparam int unsigned ANGLE_UNIT      = 1 << srpi_pkg::ANGLE_FRAC_BITS;
   localparam int unsigned ANGLE_TOP       = (1 << srpi_pkg::ANGLE_W) - 1;
   localparam int unsigned PIX_TOP         = (1 << srpi_pkg::PIX_W) - 1;
   localparam int unsigned RING_TOP        = (1 << srpi_pkg::RING_W) - 1;
   localparam int unsigned COL_TOP         = (1 << srpi_pkg::COL_W) - 1;
   localparam int          HOLD_OFF_CYCLES = 300;
   localparam int          WATCHDOG_LIMIT  = 5000;
   localparam int          DRAIN_CYCLES    = 32;
   localparam int          WIDE_LAST_SLOT  = 255;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   srpi_pkg::req_payload_type  req_payload;
   logic                       rsp_valid;
   logic                       rsp_stall;
   srpi_pkg::rsp_payload_type  rsp_payload;
   logic                       csr_write;
   logic [srpi_pkg::CSR_W-1:0] csr_wdata;

   int error_count;
   int checked_count;
   int pending_count;

   // Stimulus bookkeeping: the table as loaded and the ring count in use
   logic [srpi_pkg::PIX_W-1:0] shadow_start [0:MAX_RINGS];
   int unsigned                rings_now = 2;
   int                         op_count [4] = '{0, 0, 0, 0};
   int                         setting_count = 0;
   bit                         req_idle_on = 1'b1;
   bit                         rsp_idle_on = 1'b1;
   int                         hold_off_asks = 0;

   always #2 clock = ~clock;

   sphere_ring_pixel_indexer #(
      .MAX_RINGS (MAX_RINGS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_wdata   (csr_wdata)
   );

   srpi_result_checker #(
      .MAX_RINGS (MAX_RINGS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_write     (csr_write),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .checked_count (checked_count),
      .pending_count (pending_count)
   );

   // Size of ring k in the table as loaded
   function automatic logic [srpi_pkg::PIX_W-1:0] shadow_size(input int unsigned k);
      return shadow_start[k + 1] - shadow_start[k];
   endfunction

   // Fill every field with noise, then place the operands of the operation
   function automatic srpi_pkg::req_payload_type build_request(
         input logic [srpi_pkg::OP_W-1:0] op,
         input int unsigned a,
         input int unsigned b);
      logic [127:0]              noise;
      srpi_pkg::req_payload_type item;
      noise = {$urandom, $urandom, $urandom, $urandom};
      item  = noise[$bits(srpi_pkg::req_payload_type)-1:0];
      item.op = op;
      case (op)
         srpi_pkg::OP_LOAD: begin
            item.ring             = srpi_pkg::RING_W'(a);
            item.cumulative_count = srpi_pkg::PIX_W'(b);
         end
         srpi_pkg::OP_ANGLE: begin
            item.theta = srpi_pkg::ANGLE_W'(a);
            item.phi   = srpi_pkg::ANGLE_W'(b);
         end
         srpi_pkg::OP_DECODE: item.pixel = srpi_pkg::PIX_W'(a);
         default: begin
            item.ring   = srpi_pkg::RING_W'(a);
            item.column = srpi_pkg::COL_W'(b);
         end
      endcase
      return item;
   endfunction

   // Offer one request, with random idle cycles first, and hold until taken
   task automatic send_op(input logic [srpi_pkg::OP_W-1:0] op, input int unsigned a,
                          input int unsigned b);
      srpi_pkg::req_payload_type item;
      item = build_request(op, a, b);
      while (req_idle_on && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      op_count[item.op]++;
      if (item.op == srpi_pkg::OP_LOAD && item.ring <= MAX_RINGS)
         shadow_start[item.ring] = item.cumulative_count;
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Write the ring count register once the block is idle
   task automatic write_ring_count(input int unsigned value);
      drain_results();
      csr_write <= 1'b1;
      csr_wdata <= srpi_pkg::CSR_W'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      rings_now = (value < 2) ? 2 : (value > MAX_RINGS) ? MAX_RINGS : value;
      setting_count++;
   endtask

   // Load slots 0 to last_slot; the wide profile has rings above 4095 and wraps
   task automatic load_full_table(input bit wide, input int last_slot);
      logic [srpi_pkg::PIX_W-1:0] running;
      int unsigned                roll;
      running = wide ? srpi_pkg::PIX_W'($urandom) : '0;
      for (int slot = 0; slot <= last_slot; slot++) begin
         send_op(srpi_pkg::OP_LOAD, slot, running);
         roll = $urandom_range(99);
         if (roll < 10) running = running;
         else if (wide && roll < 40)
            running = running + srpi_pkg::PIX_W'($urandom_range(8191, 4096));
         else if (wide) running = running + srpi_pkg::PIX_W'($urandom_range(4095, 1));
         else running = running + srpi_pkg::PIX_W'($urandom_range(1500, 1));
      end
   endtask

   // Short directed pass over field extremes and each corner case
   task automatic run_directed();
      logic [srpi_pkg::PIX_W-1:0] total;
      // empty ring 3, hit out-of-range slots and both end slots
      send_op(srpi_pkg::OP_LOAD, 4, shadow_start[3]);
      send_op(srpi_pkg::OP_LOAD, MAX_RINGS + 1, $urandom);
      send_op(srpi_pkg::OP_LOAD, RING_TOP, PIX_TOP);
      send_op(srpi_pkg::OP_LOAD, MAX_RINGS, shadow_start[MAX_RINGS]);
      send_op(srpi_pkg::OP_LOAD, 0, shadow_start[0]);
      // angle extremes, theta checked before phi, and the empty ring
      send_op(srpi_pkg::OP_ANGLE, 0, 0);
      send_op(srpi_pkg::OP_ANGLE, ANGLE_UNIT, ANGLE_UNIT);
      send_op(srpi_pkg::OP_ANGLE, ANGLE_UNIT + 1, 0);
      send_op(srpi_pkg::OP_ANGLE, ANGLE_TOP, ANGLE_TOP);
      send_op(srpi_pkg::OP_ANGLE, 0, ANGLE_UNIT + 1);
      send_op(srpi_pkg::OP_ANGLE, ANGLE_UNIT, ANGLE_TOP);
      send_op(srpi_pkg::OP_ANGLE, (3 * ANGLE_UNIT) / (rings_now - 1), 40000);
      send_op(srpi_pkg::OP_ANGLE, ANGLE_UNIT / 2, ANGLE_UNIT - 1);
      // decode at both ends of the table, past it, and on a ring boundary
      total = shadow_start[rings_now];
      send_op(srpi_pkg::OP_DECODE, 0, 0);
      send_op(srpi_pkg::OP_DECODE, total - 1, 0);
      send_op(srpi_pkg::OP_DECODE, total, 0);
      send_op(srpi_pkg::OP_DECODE, PIX_TOP, 0);
      send_op(srpi_pkg::OP_DECODE, shadow_start[5], 0);
      // encode at ring and column limits
      send_op(srpi_pkg::OP_ENCODE, 0, 0);
      send_op(srpi_pkg::OP_ENCODE, rings_now - 1, shadow_size(rings_now - 1) - 1);
      send_op(srpi_pkg::OP_ENCODE, rings_now, 0);
      send_op(srpi_pkg::OP_ENCODE, RING_TOP, COL_TOP);
      send_op(srpi_pkg::OP_ENCODE, 5, shadow_size(5));
      send_op(srpi_pkg::OP_ENCODE, 3, 0);
      send_op(srpi_pkg::OP_ENCODE, 0, COL_TOP);
   endtask

   // Random requests, mostly in range, the rest out of range
   task automatic run_random(input int count);
      int unsigned                roll;
      bit                         good;
      int unsigned                a;
      int unsigned                b;
      int unsigned                lo_v;
      int unsigned                hi_v;
      logic [srpi_pkg::PIX_W-1:0] size;
      logic [srpi_pkg::OP_W-1:0]  op;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         good = ($urandom_range(99) < 85);
         op   = (roll < 10) ? srpi_pkg::OP_LOAD : (roll < 40) ? srpi_pkg::OP_ANGLE :
                (roll < 70) ? srpi_pkg::OP_DECODE : srpi_pkg::OP_ENCODE;
         case (op)
            srpi_pkg::OP_LOAD: begin
               if (good) begin
                  // keep the slot between its neighbors where they are sorted
                  a    = $urandom_range(MAX_RINGS);
                  lo_v = (a == 0) ? 0 : shadow_start[a - 1];
                  hi_v = (a == MAX_RINGS) ? lo_v + 1000 : shadow_start[a + 1];
                  if ($urandom_range(99) < 30) b = $urandom;
                  else if (hi_v >= lo_v) b = $urandom_range(hi_v, lo_v);
                  else b = shadow_start[a];
               end else begin
                  a = $urandom_range(RING_TOP, MAX_RINGS + 1);
                  b = $urandom;
               end
            end
            srpi_pkg::OP_ANGLE: begin
               a = $urandom_range(ANGLE_UNIT);
               b = $urandom_range(ANGLE_UNIT);
               if (!good && $urandom_range(1)) begin
                  a = $urandom_range(ANGLE_TOP, ANGLE_UNIT + 1);
                  b = $urandom_range(ANGLE_TOP);
               end else if (!good) begin
                  b = $urandom_range(ANGLE_TOP, ANGLE_UNIT + 1);
               end
            end
            srpi_pkg::OP_DECODE: begin
               b = 0;
               if (good && shadow_start[rings_now] != 0)
                  a = $urandom_range(shadow_start[rings_now] - 1);
               else
                  a = $urandom_range(PIX_TOP, shadow_start[rings_now]);
            end
            default: begin
               a    = $urandom_range(rings_now - 1);
               size = shadow_size(a);
               if (good) begin
                  if (size == 0) b = $urandom_range(COL_TOP);
                  else if (size > COL_TOP) b = $urandom_range(COL_TOP);
                  else b = $urandom_range(size - 1);
               end else if ($urandom_range(1) == 0 && size <= COL_TOP) begin
                  b = $urandom_range(COL_TOP, size);
               end else begin
                  a = $urandom_range(RING_TOP, rings_now);
                  b = $urandom_range(COL_TOP);
               end
            end
         endcase
         send_op(op, a, b);
      end
   endtask

   // Result side: random stalls, plus a long hold-off when asked
   initial begin : result_receiver
      int hold_off_seen;
      hold_off_seen = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_asks != hold_off_seen) begin
            hold_off_seen = hold_off_asks;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_stall <= rsp_idle_on && ($urandom_range(99) < 31);
      end
   end

   // End the run when no handshake happens for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_write   = 1'b0;
      csr_wdata   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // fill the table, then run at the reset ring count
      load_full_table(1'b0, MAX_RINGS);
      run_random(80);

      write_ring_count(16);
      run_directed();

      // largest ring count, no idling, and a long result hold-off
      write_ring_count(MAX_RINGS);
      req_idle_on = 1'b0;
      rsp_idle_on <= 1'b0;
      run_random(100);
      hold_off_asks <= hold_off_asks + 1;
      run_random(150);
      req_idle_on = 1'b1;
      rsp_idle_on <= 1'b1;

      // ring counts below the minimum saturate to two
      write_ring_count(0);
      run_random(60);
      write_ring_count(1);
      run_random(40);

      // wide, wrapping table start with ring counts above the maximum
      write_ring_count(RING_TOP);
      load_full_table(1'b1, WIDE_LAST_SLOT);
      run_random(120);
      write_ring_count(MAX_RINGS + 1);
      run_random(60);

      repeat (3) begin
         write_ring_count($urandom_range(MAX_RINGS - 1, 3));
         run_random(60);
      end

      // let the block settle after the last result
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d loads, %0d angle, %0d decode, %0d encode.",
               op_count[srpi_pkg::OP_LOAD] + op_count[srpi_pkg::OP_ANGLE] +
               op_count[srpi_pkg::OP_DECODE] + op_count[srpi_pkg::OP_ENCODE],
               op_count[srpi_pkg::OP_LOAD], op_count[srpi_pkg::OP_ANGLE],
               op_count[srpi_pkg::OP_DECODE], op_count[srpi_pkg::OP_ENCODE]);
      $display("Ring-count settings written: %0d; results compared: %0d; mismatches: %0d.",
               setting_count, checked_count, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
